// ===== rtl/core/hc_pkg.sv =====
package hc_pkg;

   localparam int Alpha        = 26;
   localparam int LetterW      = 5;
   localparam int KeyRowW      = 15;
   localparam int CsrIndexW    = 2;
   localparam int QueueDepth   = 2;
   localparam int DeriveCycles = 7;
   // floor(2^16 / 26), so the estimated quotient never runs high
   localparam int RecipMul     = 2520;
   localparam int CrossBias    = Alpha * Alpha;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_KEY_ROW_ZERO = 2'd0,
      CSR_KEY_ROW_ONE  = 2'd1,
      CSR_KEY_ROW_TWO  = 2'd2,
      CSR_DECRYPT_MODE = 2'd3
   } csr_index_type;

   typedef logic [LetterW-1:0] letter_type;

   // row-major 3x3 matrix of letters
   typedef letter_type [8:0] matrix_type;

   localparam letter_type PadLetter = letter_type'(23);

   typedef struct packed {
      letter_type [2:0] letter;
      logic             msg_end;
   } block_type;

   typedef struct packed {
      matrix_type inverse;
      logic       invertible;
      logic       busy;
   } key_status_type;

   typedef struct packed {
      logic block_last;
      logic message_done;
      logic key_error;
   } row_flags_type;

   // one compare and subtract: a 5-bit value stays below twice the modulus
   function automatic letter_type reduce_letter(input letter_type x);
      return (x >= letter_type'(Alpha)) ? x - letter_type'(Alpha) : x;
   endfunction

   // x mod 26 by reciprocal multiply, quotient is exact or one low
   function automatic letter_type mod_alpha(input logic [15:0] x);
      logic [27:0] prod;
      logic [15:0] quot;
      logic [15:0] rem;
      prod = 28'(x) * 28'(RecipMul);
      quot = 16'(prod[27:16]);
      rem  = x - 16'(quot * 16'(Alpha));
      if (rem >= 16'(Alpha)) begin
         rem = rem - 16'(Alpha);
      end
      return letter_type'(rem);
   endfunction

   // multiplicative inverse mod 26, msb set when it exists
   function automatic logic [LetterW:0] inverse_lookup(input letter_type det);
      logic [LetterW:0] res;
      unique case (det)
         5'd1:    res = {1'b1, 5'd1};
         5'd3:    res = {1'b1, 5'd9};
         5'd5:    res = {1'b1, 5'd21};
         5'd7:    res = {1'b1, 5'd15};
         5'd9:    res = {1'b1, 5'd3};
         5'd11:   res = {1'b1, 5'd19};
         5'd15:   res = {1'b1, 5'd7};
         5'd17:   res = {1'b1, 5'd23};
         5'd19:   res = {1'b1, 5'd11};
         5'd21:   res = {1'b1, 5'd5};
         5'd23:   res = {1'b1, 5'd17};
         5'd25:   res = {1'b1, 5'd25};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/core/hc_keygen.sv =====
module hc_keygen (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   key_write,
   input  hc_pkg::matrix_type     key,
   output hc_pkg::key_status_type status
);

   localparam int CountW = $clog2(hc_pkg::DeriveCycles + 1);

   logic [10:0] cross_ff [9];
   logic [10:0] cross_in [9];
   hc_pkg::matrix_type adj_ff;
   logic [10:0] det_raw_ff;
   hc_pkg::letter_type det_ff;
   hc_pkg::letter_type inv_det_ff;
   logic found_ff;
   logic found_d_ff;
   logic [9:0] prod_ff [9];
   hc_pkg::matrix_type inverse_ff;
   logic invertible_ff;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic [10:0] det_raw_in;
   logic [hc_pkg::LetterW:0] lookup;

   // cofactor (a*b - c*d) biased positive, element (i,j) of the adjugate
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int IdxA = ((j + 1) % 3) * 3 + (i + 1) % 3;
         localparam int IdxB = ((j + 2) % 3) * 3 + (i + 2) % 3;
         localparam int IdxC = ((j + 1) % 3) * 3 + (i + 2) % 3;
         localparam int IdxD = ((j + 2) % 3) * 3 + (i + 1) % 3;
         assign cross_in[i*3+j] = 11'(key[IdxA] * key[IdxB]) + 11'(hc_pkg::CrossBias)
                                  - 11'(key[IdxC] * key[IdxD]);
      end
   end

   assign det_raw_in = 11'(key[0] * adj_ff[0]) + 11'(key[1] * adj_ff[3])
                       + 11'(key[2] * adj_ff[6]);
   assign lookup     = hc_pkg::inverse_lookup(det_ff);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         cross_ff[k]   <= cross_in[k];
         adj_ff[k]     <= hc_pkg::mod_alpha(16'(cross_ff[k]));
         prod_ff[k]    <= 10'(adj_ff[k] * inv_det_ff);
         inverse_ff[k] <= found_d_ff ? hc_pkg::mod_alpha(16'(prod_ff[k])) : '0;
      end
      det_raw_ff    <= det_raw_in;
      det_ff        <= hc_pkg::mod_alpha(16'(det_raw_ff));
      inv_det_ff    <= lookup[hc_pkg::LetterW-1:0];
      found_ff      <= lookup[hc_pkg::LetterW];
      found_d_ff    <= found_ff;
      invertible_ff <= found_d_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (key_write) begin
         count_in = CountW'(hc_pkg::DeriveCycles);
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountW'(hc_pkg::DeriveCycles);
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.inverse    = inverse_ff;
   assign status.invertible = invertible_ff;
   assign status.busy       = (count_ff != '0);

endmodule

// ===== rtl/core/hc_front.sv =====
module hc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  hc_pkg::letter_type letter_in,
   input  logic               message_end,
   output logic               push,
   output hc_pkg::block_type  block
);

   logic [1:0] count_ff;
   logic [1:0] count_in;
   hc_pkg::letter_type pending_ff [2];
   hc_pkg::letter_type letter;
   logic complete;

   assign letter   = hc_pkg::reduce_letter(letter_in);
   assign complete = (count_ff == 2'd2) || message_end;
   assign push     = accept && complete;

   // pad the unused places of a short final block
   always_comb begin
      block.letter[0] = (count_ff == 2'd0) ? letter : pending_ff[0];
      block.letter[1] = (count_ff == 2'd1) ? letter :
                        (count_ff == 2'd2) ? pending_ff[1] : hc_pkg::PadLetter;
      block.letter[2] = (count_ff == 2'd2) ? letter : hc_pkg::PadLetter;
      block.msg_end   = message_end;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = complete ? 2'd0 : count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !complete) begin
         pending_ff[count_ff[0]] <= letter;
      end
   end

endmodule

// ===== rtl/core/hc_queue.sv =====
module hc_queue #(
   parameter int Depth = hc_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hc_pkg::block_type push_data,
   input  logic              pop,
   output hc_pkg::block_type head,
   output logic              not_empty,
   output logic              full
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   hc_pkg::block_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;

   assign wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CountW'(Depth));

endmodule

// ===== rtl/core/hc_back.sv =====
module hc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  hc_pkg::block_type      head,
   input  logic                   head_valid,
   output logic                   pop,
   input  hc_pkg::matrix_type     key,
   input  hc_pkg::key_status_type status,
   input  logic                   decrypt,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hc_pkg::letter_type     out_letter,
   output hc_pkg::row_flags_type  out_flags
);

   localparam logic [1:0] LastRow = 2'd2;

   logic [1:0] row_ff;
   logic advance;
   logic take;
   logic [3:0] base;
   hc_pkg::letter_type m [3];
   logic [10:0] acc_in;
   hc_pkg::row_flags_type flags_in;

   logic a_valid_ff;
   logic [10:0] acc_ff;
   hc_pkg::row_flags_type a_flags_ff;
   logic out_valid_ff;
   hc_pkg::letter_type out_letter_ff;
   hc_pkg::row_flags_type out_flags_ff;

   // whole back end moves when the output register is free or drained
   assign advance = !out_valid_ff || out_ready;
   assign take    = advance && head_valid;
   assign pop     = take && (row_ff == LastRow);
   assign base    = 4'({row_ff, 1'b0}) + 4'(row_ff);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         m[j] = decrypt ? status.inverse[base + 4'(j)] : key[base + 4'(j)];
      end
      acc_in = 11'(m[0] * head.letter[0]) + 11'(m[1] * head.letter[1])
               + 11'(m[2] * head.letter[2]);
      flags_in.block_last   = (row_ff == LastRow);
      flags_in.message_done = (row_ff == LastRow) && head.msg_end;
      flags_in.key_error    = decrypt && !status.invertible;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= 2'd0;
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            row_ff <= (row_ff == LastRow) ? 2'd0 : row_ff + 2'd1;
         end
         if (advance) begin
            a_valid_ff   <= take;
            out_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff        <= acc_in;
         a_flags_ff    <= flags_in;
         out_letter_ff <= a_flags_ff.key_error ? '0 : hc_pkg::mod_alpha(16'(acc_ff));
         out_flags_ff  <= a_flags_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_letter = out_letter_ff;
   assign out_flags  = out_flags_ff;

endmodule

// ===== rtl/core/hill_cipher_3x3_mod26_unit.sv =====
// 3x3 hill cipher over the 26-letter alphabet
// req channel: one letter per transaction, tlast marks the last letter of a message.
// letters are grouped in threes; a message end that leaves only one or two letters in
// a block pads it with X. each completed block yields three rsp transactions, one per
// cycle unless rsp stalls, tlast on the third letter of the message's last block.
// csr port: write-only key rows 0..2 (three 5-bit entries each) and decrypt mode.
// a key row write starts a derivation of the inverse key (cofactors, determinant,
// inverse lookup, scaling); req_tready stays low until it is done.
// each result letter is summed into an accumulator register and then reduced
// mod 26 into the output register.
// throughput: one letter per cycle in and out while rsp is not stalled and no key
// derivation runs; the output side emits one row per cycle from a shared dot-product
// unit and an output register. a 2-block queue sits between the collector and the
// dot-product unit; when rsp_tready is low the unit holds, the queue fills and then
// req_tready drops. reset: key is the identity, encrypt mode, nothing held;
// req_tready stays low after reset ends while the identity inverse is derived.
module hill_cipher_3x3_mod26_unit #(
   parameter int QueueDepth = hc_pkg::QueueDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   // request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [4:0] letter_in, rest zero
   input  logic                         req_tlast,   // message_end
   // response stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [4:0] letter_out, rest zero
   output logic [1:0]                   rsp_tuser,   // [0] block_last, [1] key_error
   output logic                         rsp_tlast,   // message_done
   // configuration writes
   input  logic                         csr_we,
   input  logic [hc_pkg::CsrIndexW-1:0] csr_index,
   input  logic [hc_pkg::KeyRowW-1:0]   csr_wdata
);

   hc_pkg::matrix_type key_ff;
   hc_pkg::matrix_type key_in;
   logic decrypt_ff;
   logic decrypt_in;
   logic key_write;

   hc_pkg::key_status_type status;
   logic req_accept;
   logic push;
   hc_pkg::block_type push_block;
   hc_pkg::block_type head;
   logic head_valid;
   logic queue_full;
   logic pop;
   hc_pkg::letter_type out_letter;
   hc_pkg::row_flags_type out_flags;

   // configuration registers, key entries reduced mod 26 as they are written
   always_comb begin
      key_in     = key_ff;
      decrypt_in = decrypt_ff;
      key_write  = 1'b0;
      if (csr_we) begin
         unique case (hc_pkg::csr_index_type'(csr_index))
            hc_pkg::CSR_KEY_ROW_ZERO, hc_pkg::CSR_KEY_ROW_ONE, hc_pkg::CSR_KEY_ROW_TWO: begin
               key_write = 1'b1;
               for (int j = 0; j < 3; j++) begin
                  key_in[4'({csr_index, 1'b0}) + 4'(csr_index) + 4'(j)] =
                     hc_pkg::reduce_letter(csr_wdata[5*j +: hc_pkg::LetterW]);
               end
            end
            hc_pkg::CSR_DECRYPT_MODE: begin
               decrypt_in = csr_wdata[0];
            end
            default: begin
               decrypt_in = decrypt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            key_ff[k] <= (k % 4 == 0) ? hc_pkg::letter_type'(1) : '0;
         end
         decrypt_ff <= 1'b0;
      end else begin
         key_ff     <= key_in;
         decrypt_ff <= decrypt_in;
      end
   end

   // inverse key derivation
   hc_keygen u_keygen (
      .clock     (clock),
      .reset     (reset),
      .key_write (key_write),
      .key       (key_ff),
      .status    (status)
   );

   // front: take letters while the inverse is settled and the queue has room
   assign req_tready = !status.busy && !queue_full;
   assign req_accept = req_tvalid && req_tready;

   hc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .letter_in   (req_tdata[hc_pkg::LetterW-1:0]),
      .message_end (req_tlast),
      .push        (push),
      .block       (push_block)
   );

   // completed blocks wait here for the dot-product unit
   hc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_block),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   // back: one matrix row per cycle into the output register, holding while rsp is stalled
   hc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .key        (key_ff),
      .status     (status),
      .decrypt    (decrypt_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_letter (out_letter),
      .out_flags  (out_flags)
   );

   assign rsp_tdata = {3'b000, out_letter};
   assign rsp_tuser = {out_flags.key_error, out_flags.block_last};
   assign rsp_tlast = out_flags.message_done;

endmodule
